// ===== hw/rtl/chained_hash_table_engine_assert.svh =====
// assertion macros used by the hash table rtl
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication, checked on clk and masked during rst
`define CHT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk and masked during rst
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cht_pkg.sv =====
// shared constants and types of the chained hash table engine
`default_nettype none

package cht_pkg;

  // field widths
  localparam int KEY_W     = 64;
  localparam int SLOT_W    = 8;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 64;

  // low hash bits that can reach the bucket index (width of bucket_count)
  localparam int HASH_W = 11;

  // default geometry
  localparam int DEF_BUCKETS = 1024;
  localparam int DEF_ENTRIES = 256;

  // multiplicative hash constant
  localparam logic [KEY_W-1:0] GOLDEN = 64'h9E3779B97F4A7C15;

  // reset value of the bucket count register
  localparam logic [HASH_W-1:0] BUCKET_COUNT_RESET = 11'd1024;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'd1;

  // result word handed from the table core to the output stage
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chained_hash_table_engine.sv =====
// Hash table with separate chaining over a pool of slots. After reset the block clears its
// BUCKETS bucket heads (1024 by default), one per cycle, and takes no word until done;
// configuration writes are taken throughout. Each lookup, insert or remove word runs through
// the hash pipeline (multiply, reciprocal estimate, wrap) and a registered read of the bucket
// head memory; a lookup or remove then walks the chain with one entry memory read per link,
// and an unused command goes straight to its result. A new word is taken only once the last
// result is in an output register, which holds it so the next word can be accepted meanwhile.
`default_nettype none

module chained_hash_table_engine #(
  parameter int BUCKETS = cht_pkg::DEF_BUCKETS,
  parameter int ENTRIES = cht_pkg::DEF_ENTRIES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [cht_pkg::CMD_W-1:0]      command,
  input  wire logic [cht_pkg::KEY_W-1:0]      key,
  input  wire logic [cht_pkg::SLOT_W-1:0]     entry_slot,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                found,
  output logic [cht_pkg::SLOT_W-1:0]          result_slot,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cht_pkg::CFG_W-1:0]      cfg_data
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int HW = cht_pkg::HASH_W;

  logic [HW-1:0]    hash_seed;
  logic [HW-1:0]    bucket_count;
  logic             in_accept;
  logic             core_idle;
  logic             hash_done;
  logic [BW-1:0]    bucket;
  logic             res_valid;
  logic             res_take;
  cht_pkg::result_t res;

  assign in_ready  = core_idle;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign res_take  = !out_valid || out_ready;

  // configuration registers; only the low seed bits reach the bucket index
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed    <= '0;
      bucket_count <= cht_pkg::BUCKET_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cht_pkg::REG_HASH_SEED:    hash_seed    <= cfg_data[HW-1:0];
        cht_pkg::REG_BUCKET_COUNT: bucket_count <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // bucket index pipeline
  cht_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk          (clk),
    .rst          (rst),
    .start        (in_accept && (command inside {cht_pkg::CMD_LOOKUP, cht_pkg::CMD_INSERT,
                                                  cht_pkg::CMD_REMOVE})),
    .key_bits     (key[HW-1:0]),
    .seed_bits    (hash_seed),
    .bucket_count (bucket_count),
    .done         (hash_done),
    .bucket       (bucket)
  );

  // table sequencer and memories
  cht_core #(
    .BUCKETS (BUCKETS),
    .ENTRIES (ENTRIES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (in_accept),
    .command    (command),
    .key        (key),
    .entry_slot (entry_slot),
    .idle       (core_idle),
    .hash_done  (hash_done),
    .bucket     (bucket),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      found       <= res.found;
      result_slot <= res.slot;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cht_hash.sv =====
// bucket index pipeline: multiply, reciprocal estimate, wrap
`default_nettype none

module cht_hash #(
  parameter int  BUCKETS = cht_pkg::DEF_BUCKETS,
  localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [cht_pkg::HASH_W-1:0] key_bits,
  input  wire logic [cht_pkg::HASH_W-1:0] seed_bits,
  input  wire logic [cht_pkg::HASH_W-1:0] bucket_count,
  output logic                            done,
  output logic [BW-1:0]                   bucket
);

  localparam int HW     = cht_pkg::HASH_W;
  localparam int RSHIFT = HW + 1;
  localparam int RECIP  = (1 << RSHIFT) / BUCKETS;
  localparam int QPW    = HW + RSHIFT + 1;
  localparam logic [HW-1:0] GOLD_LOW = cht_pkg::GOLDEN[HW-1:0];

  logic          v1;
  logic          v2;
  logic [HW-1:0] hmask;
  logic [HW-1:0] hq;

  logic [HW-1:0]   prod;
  logic [HW-1:0]   mask;
  logic [QPW-1:0]  qprod;
  logic [HW-1:0]   qb;
  logic [HW-1:0]   rem;
  logic [HW-1:0]   rem_fix;

  // low product bits only depend on low operand bits
  assign prod  = (key_bits ^ seed_bits) * GOLD_LOW;
  assign mask  = bucket_count - 1'b1;

  // quotient estimate by reciprocal, off by at most one
  assign qprod = QPW'(hmask) * QPW'(RECIP);

  // remainder with a single correction step
  assign qb      = HW'(32'(hq) * 32'(BUCKETS));
  assign rem     = hmask - qb;
  assign rem_fix = (32'(rem) >= BUCKETS) ? (rem - HW'(BUCKETS)) : rem;

  assign bucket = BW'(rem_fix);
  assign done   = v2;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (start) begin
      hmask <= prod & mask;
    end
    if (v1) begin
      hq <= HW'(qprod >> RSHIFT);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cht_core.sv =====
// table sequencer with bucket head memory and slot entry memory
`default_nettype none

`include "chained_hash_table_engine_assert.svh"

module cht_core #(
  parameter int  BUCKETS = cht_pkg::DEF_BUCKETS,
  parameter int  ENTRIES = cht_pkg::DEF_ENTRIES,
  localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
  localparam int SW      = $clog2(ENTRIES)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cht_pkg::CMD_W-1:0]   command,
  input  wire logic [cht_pkg::KEY_W-1:0]   key,
  input  wire logic [cht_pkg::SLOT_W-1:0]  entry_slot,
  output logic                             idle,
  input  wire logic                        hash_done,
  input  wire logic [BW-1:0]               bucket,
  output logic                             res_valid,
  output cht_pkg::result_t                 res,
  input  wire logic                        res_take
);

  localparam int KW  = cht_pkg::KEY_W;
  localparam int EW  = KW + 1 + SW;
  localparam int STW = $clog2(ENTRIES + 1);
  localparam int PW  = cht_pkg::SLOT_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_HEAD  = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [BW-1:0]               clr_addr, clr_addr_next;
  logic [cht_pkg::CMD_W-1:0]   cmd_q, cmd_q_next;
  logic [KW-1:0]               key_q, key_q_next;
  logic [PW-1:0]               slot_q, slot_q_next;
  logic [BW-1:0]               bucket_q, bucket_q_next;
  logic [SW-1:0]               cur_slot, cur_slot_next;
  logic                        prev_valid, prev_valid_next;
  logic [SW-1:0]               prev_slot, prev_slot_next;
  logic [KW-1:0]               prev_key, prev_key_next;
  logic [STW-1:0]              steps, steps_next;
  logic                        res_found, res_found_next;
  logic [PW-1:0]               res_slot, res_slot_next;

  // head memory: link valid and slot per bucket
  logic [SW:0]   head_mem [BUCKETS];
  logic [SW:0]   head_rdata;
  logic          head_we, head_re;
  logic [BW-1:0] head_waddr, head_raddr;
  logic [SW:0]   head_wdata;

  // entry memory: key, link valid and next slot per slot
  logic [EW-1:0] entry_mem [ENTRIES];
  logic [EW-1:0] entry_rdata;
  logic          entry_we, entry_re;
  logic [SW-1:0] entry_waddr, entry_raddr;
  logic [EW-1:0] entry_wdata;

  logic [KW-1:0] rd_key;
  logic [SW:0]   rd_link;

  assign rd_key  = entry_rdata[EW-1 -: KW];
  assign rd_link = entry_rdata[SW:0];

  // sequencer
  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    cmd_q_next      = cmd_q;
    key_q_next      = key_q;
    slot_q_next     = slot_q;
    bucket_q_next   = bucket_q;
    cur_slot_next   = cur_slot;
    prev_valid_next = prev_valid;
    prev_slot_next  = prev_slot;
    prev_key_next   = prev_key;
    steps_next      = steps;
    res_found_next  = res_found;
    res_slot_next   = res_slot;
    head_we         = 1'b0;
    head_waddr      = bucket_q;
    head_wdata      = '0;
    head_re         = 1'b0;
    head_raddr      = bucket;
    entry_we        = 1'b0;
    entry_waddr     = SW'(slot_q);
    entry_wdata     = {key_q, head_rdata};
    entry_re        = 1'b0;
    entry_raddr     = head_rdata[SW-1:0];

    case (state)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_addr;
        if (clr_addr == BW'(BUCKETS - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_q_next  = command;
          key_q_next  = key;
          slot_q_next = entry_slot;
          if (command inside {cht_pkg::CMD_LOOKUP, cht_pkg::CMD_INSERT,
                              cht_pkg::CMD_REMOVE}) begin
            state_next = S_HASH;
          end else begin
            res_found_next = 1'b0;
            res_slot_next  = '0;
            state_next     = S_DONE;
          end
        end
      end

      // issue the head read as soon as the bucket index is out
      S_HASH: begin
        if (hash_done) begin
          head_re       = 1'b1;
          bucket_q_next = bucket;
          state_next    = S_HEAD;
        end
      end

      S_HEAD: begin
        if (cmd_q == cht_pkg::CMD_INSERT) begin
          if (32'(slot_q) >= ENTRIES) begin
            res_found_next = 1'b0;
            res_slot_next  = '0;
          end else begin
            // new slot takes the old head as its link
            entry_we       = 1'b1;
            head_we        = 1'b1;
            head_wdata     = {1'b1, SW'(slot_q)};
            res_found_next = 1'b1;
            res_slot_next  = slot_q;
          end
          state_next = S_DONE;
        end else if (!head_rdata[SW]) begin
          res_found_next = 1'b0;
          res_slot_next  = '0;
          state_next     = S_DONE;
        end else begin
          entry_re        = 1'b1;
          cur_slot_next   = head_rdata[SW-1:0];
          prev_valid_next = 1'b0;
          steps_next      = STW'(1);
          state_next      = S_WALK;
        end
      end

      // one chain link per cycle
      S_WALK: begin
        if (rd_key == key_q) begin
          if (cmd_q == cht_pkg::CMD_REMOVE) begin
            if (prev_valid) begin
              entry_we    = 1'b1;
              entry_waddr = prev_slot;
              entry_wdata = {prev_key, rd_link};
            end else begin
              head_we    = 1'b1;
              head_wdata = rd_link;
            end
          end
          res_found_next = 1'b1;
          res_slot_next  = PW'(cur_slot);
          state_next     = S_DONE;
        end else if (!rd_link[SW] || (steps == STW'(ENTRIES))) begin
          res_found_next = 1'b0;
          res_slot_next  = '0;
          state_next     = S_DONE;
        end else begin
          entry_re        = 1'b1;
          entry_raddr     = rd_link[SW-1:0];
          cur_slot_next   = rd_link[SW-1:0];
          prev_valid_next = 1'b1;
          prev_slot_next  = cur_slot;
          prev_key_next   = rd_key;
          steps_next      = steps + 1'b1;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_q      <= cmd_q_next;
    key_q      <= key_q_next;
    slot_q     <= slot_q_next;
    bucket_q   <= bucket_q_next;
    cur_slot   <= cur_slot_next;
    prev_valid <= prev_valid_next;
    prev_slot  <= prev_slot_next;
    prev_key   <= prev_key_next;
    steps      <= steps_next;
    res_found  <= res_found_next;
    res_slot   <= res_slot_next;
  end

  // head memory port
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rdata <= head_mem[head_raddr];
    end
  end

  // entry memory port
  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= entry_wdata;
    end
    if (entry_re) begin
      entry_rdata <= entry_mem[entry_raddr];
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{found: res_found, slot: res_slot};

  // checks
  `CHT_ASSERT_IMPL(a_head_write_state, head_we, (state == S_CLEAR) || (state == S_HEAD) || (state == S_WALK), "head memory written outside clear or update")
  `CHT_ASSERT_IMPL(a_hash_while_waiting, hash_done, state == S_HASH, "bucket index arrived while not waiting for it")
  `CHT_ASSERT_IMPL(a_walk_bound, state == S_WALK, (steps != '0) && (32'(steps) <= ENTRIES), "chain walk count out of bounds")
  `CHT_ASSERT_NEXT(a_start_leaves_idle, start && idle, state != S_IDLE, "accepted word left the sequencer idle")
  `CHT_ASSERT_IMPL(a_entry_port_exclusive, entry_we, !entry_re, "entry memory read and written in one cycle")

endmodule

`default_nettype wire
